// File: design/hsvh_pkg.sv
// Package for the HSV block histogram: action codes, register indexes,
// store geometry and the hue band edges. No dependencies.
package hsvh_pkg;

    // Action codes carried by an input beat.
    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // Configuration register indexes.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Histogram geometry.
    localparam int unsigned GRID_CELLS = 16;
    localparam int unsigned BINS       = 72;
    localparam int unsigned DEPTH      = GRID_CELLS * BINS;
    localparam int unsigned ADDR_W     = $clog2(DEPTH);
    localparam int unsigned COUNT_W    = 21;
    localparam int unsigned SIDE_W     = 13;
    localparam int unsigned COORD_W    = 12;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = COUNT_W'(1048576);
    localparam logic [SIDE_W-1:0]  SIDE_RESET = SIDE_W'(256);

    // Hue band edges in degrees, ascending; the last one wraps to band 0.
    typedef logic [8:0] t_hue_edge;
    localparam t_hue_edge HUE_EDGES [7] = '{
        9'd26, 9'd41, 9'd121, 9'd191, 9'd271, 9'd296, 9'd316
    };

endpackage

// File: design/hsv_block_histogram.sv
// HSV block histogram top level: pixel to bin pipeline and the counter store.
// Depends on hsvh_pkg.
//
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall    action, column, row, rgb, cell_req, bin
// out       output     o_out_valid / i_out_stall  count
// cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// One beat is taken every clock unless o_in_stall is high. A read's count
// reaches the output after passing the input register, the HSV stage, the
// store read and the output register. The store is one memory with one
// write and one read port; an access that follows an add to the same
// counter is forwarded from the write.
// After reset, and after a clear beat drains the pipeline, a zeroing sweep
// writes all 1152 counters at one a cycle while the input is stalled.
// A stalled output holds the pipeline only while a read waits behind it.
module hsv_block_histogram #(
    parameter int MAX_SIDE = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_action,
    input  logic [hsvh_pkg::COORD_W-1:0]        i_column,
    input  logic [hsvh_pkg::COORD_W-1:0]        i_row,
    input  logic [7:0]                          i_red,
    input  logic [7:0]                          i_green,
    input  logic [7:0]                          i_blue,
    input  logic [3:0]                          i_cell_req,
    input  logic [6:0]                          i_bin,
    // Output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [hsvh_pkg::COUNT_W-1:0]        o_count,
    // Configuration
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [hsvh_pkg::SIDE_W-1:0]         i_cfg_data
);

    localparam int AW = hsvh_pkg::ADDR_W;
    localparam int CW = hsvh_pkg::COUNT_W;
    localparam int SW = hsvh_pkg::SIDE_W;

    // Clamp a side register to the largest supported image side.
    function automatic logic [SW-1:0] clamp_side(input logic [SW-1:0] v);
        logic [SW-1:0] res;
        res = v;
        if (32'(v) > 32'(MAX_SIDE)) begin
            res = SW'(MAX_SIDE);
        end
        return res;
    endfunction

    // Band of a coordinate: how many of the edges floor(k*side/4), k = 1..3,
    // lie at or below it, compared as k*side < 4*c + 4.
    function automatic logic [1:0] band_of(input logic [hsvh_pkg::COORD_W-1:0] c,
                                           input logic [SW-1:0] side);
        logic [14:0] lim;
        logic [14:0] s1;
        logic [14:0] s2;
        logic [14:0] s3;
        logic [1:0]  b;
        lim = {1'b0, c, 2'b00} + 15'd4;
        s1  = {2'b00, side};
        s2  = {1'b0, side, 1'b0};
        s3  = s1 + s2;
        b   = 2'd0;
        if (s1 < lim) b = b + 2'd1;
        if (s2 < lim) b = b + 2'd1;
        if (s3 < lim) b = b + 2'd1;
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers, stored already clamped.
    logic [SW-1:0] r_width;
    logic [SW-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= clamp_side(hsvh_pkg::SIDE_RESET);
            r_height <= clamp_side(hsvh_pkg::SIDE_RESET);
        end else if (i_cfg_we) begin
            if (i_cfg_index == hsvh_pkg::REG_HEIGHT) begin
                r_height <= clamp_side(i_cfg_data);
            end else begin
                r_width  <= clamp_side(i_cfg_data);
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control.
    logic                 w_advance;
    logic                 w_in_accept;
    logic                 r_clear_pend;
    logic                 r_sweep;
    logic [AW-1:0]        r_sweep_addr;

    logic                 r_s1_valid;
    logic                 r_s2_valid;
    logic                 r_s3_valid;
    hsvh_pkg::t_action    r_s3_action;
    logic                 r_out_valid;

    // The pipeline only waits when a read result would overwrite a stalled one.
    assign w_advance   = !(r_s3_valid && (r_s3_action == hsvh_pkg::ACT_READ) &&
                           r_out_valid && i_out_stall);
    assign o_in_stall  = r_clear_pend || r_sweep || !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // Stage 1: registered input beat.
    hsvh_pkg::t_action           r_s1_action;
    logic [hsvh_pkg::COORD_W-1:0] r_s1_column;
    logic [hsvh_pkg::COORD_W-1:0] r_s1_row;
    logic [7:0]                  r_s1_red;
    logic [7:0]                  r_s1_green;
    logic [7:0]                  r_s1_blue;
    logic [3:0]                  r_s1_cell_req;
    logic [6:0]                  r_s1_bin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_advance) begin
            r_s1_valid <= w_in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s1_action   <= hsvh_pkg::t_action'(i_action);
            r_s1_column   <= i_column;
            r_s1_row      <= i_row;
            r_s1_red      <= i_red;
            r_s1_green    <= i_green;
            r_s1_blue     <= i_blue;
            r_s1_cell_req <= i_cell_req;
            r_s1_bin      <= i_bin;
        end
    end

    // Stage 1 logic: bounds, grid cell, value and saturation bands, hue product.
    logic               w_inb;
    logic [3:0]         w_cell;
    logic [7:0]         w_mx;
    logic [7:0]         w_mn;
    logic [7:0]         w_d;
    logic [1:0]         w_vv;
    logic [1:0]         w_sv;
    logic signed [18:0] w_p_s;
    logic [16:0]        w_p;
    logic [AW-1:0]      w_read_addr;
    logic               w_read_zero;
    hsvh_pkg::t_action  w_s1_op;

    always_comb begin
        logic [11:0]        mx10;
        logic [11:0]        d10;
        logic signed [18:0] rs;
        logic signed [18:0] gs;
        logic signed [18:0] bs;
        logic signed [18:0] ds;

        w_inb  = (13'(r_s1_column) < r_width) && (13'(r_s1_row) < r_height);
        w_cell = {band_of(r_s1_column, r_width), band_of(r_s1_row, r_height)};

        // Channel extremes.
        w_mx = (r_s1_red > r_s1_green) ? r_s1_red : r_s1_green;
        if (r_s1_blue > w_mx) w_mx = r_s1_blue;
        w_mn = (r_s1_red < r_s1_green) ? r_s1_red : r_s1_green;
        if (r_s1_blue < w_mn) w_mn = r_s1_blue;
        w_d  = w_mx - w_mn;

        // Value band against 0.2 and 0.7 of full scale.
        mx10 = 12'(w_mx) * 12'd10;
        if (mx10 < 12'd510) begin
            w_vv = 2'd0;
        end else if (mx10 < 12'd1785) begin
            w_vv = 2'd1;
        end else begin
            w_vv = 2'd2;
        end

        // Saturation band: d/mx against 0.2 and 0.7; black is band 0.
        d10 = 12'(w_d) * 12'd10;
        if (w_mx == 8'd0) begin
            w_sv = 2'd0;
        end else if (d10 < 12'(w_mx) * 12'd2) begin
            w_sv = 2'd0;
        end else if (d10 < 12'(w_mx) * 12'd7) begin
            w_sv = 2'd1;
        end else begin
            w_sv = 2'd2;
        end

        // Hue times d, with red winning ties over green and green over blue.
        rs = $signed({11'b0, r_s1_red});
        gs = $signed({11'b0, r_s1_green});
        bs = $signed({11'b0, r_s1_blue});
        ds = $signed({11'b0, w_d});
        if (w_mx == r_s1_red) begin
            w_p_s = 19'sd60 * (gs - bs);
            if (w_p_s < 0) w_p_s = w_p_s + 19'sd360 * ds;
        end else if (w_mx == r_s1_green) begin
            w_p_s = 19'sd60 * (bs - rs) + 19'sd120 * ds;
        end else begin
            w_p_s = 19'sd60 * (rs - gs) + 19'sd240 * ds;
        end
        w_p = w_p_s[16:0];

        // Read address; a bin past the table reads as zero.
        w_read_zero = (r_s1_bin >= 7'(hsvh_pkg::BINS));
        w_read_addr = w_read_zero ? '0 :
                      AW'(r_s1_cell_req) * AW'(hsvh_pkg::BINS) + AW'(r_s1_bin);

        // An out-of-bounds pixel drops out as a no-op.
        w_s1_op = r_s1_action;
        if (r_s1_action == hsvh_pkg::ACT_ADD && !w_inb) w_s1_op = hsvh_pkg::ACT_NONE;
    end

    // ------------------------------------------------------------------
    // Stage 2: HSV bands registered, hue band and store address.
    hsvh_pkg::t_action r_s2_action;
    logic [3:0]        r_s2_cell;
    logic [1:0]        r_s2_vv;
    logic [1:0]        r_s2_sv;
    logic [7:0]        r_s2_d;
    logic [16:0]       r_s2_p;
    logic [AW-1:0]     r_s2_read_addr;
    logic              r_s2_read_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_advance) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s2_action    <= w_s1_op;
            r_s2_cell      <= w_cell;
            r_s2_vv        <= w_vv;
            r_s2_sv        <= w_sv;
            r_s2_d         <= w_d;
            r_s2_p         <= w_p;
            r_s2_read_addr <= w_read_addr;
            r_s2_read_zero <= w_read_zero;
        end
    end

    logic [2:0]    w_hv;
    logic [AW-1:0] w_s2_addr;

    always_comb begin
        logic [16:0] lim;
        logic [2:0]  cnt;
        cnt = 3'd1;
        // Edges before the last are ascending: count those at or below hue.
        for (int i = 0; i < 6; i++) begin
            lim = 17'(hsvh_pkg::HUE_EDGES[i]) * 17'(r_s2_d);
            if (r_s2_p >= lim) cnt = cnt + 3'd1;
        end
        lim = 17'(hsvh_pkg::HUE_EDGES[6]) * 17'(r_s2_d);
        if (r_s2_d == 8'd0) begin
            w_hv = 3'd1;
        end else if (r_s2_p >= lim) begin
            w_hv = 3'd0;
        end else begin
            w_hv = cnt;
        end

        if (r_s2_action == hsvh_pkg::ACT_READ) begin
            w_s2_addr = r_s2_read_addr;
        end else begin
            w_s2_addr = AW'(r_s2_cell) * AW'(hsvh_pkg::BINS) + AW'(w_hv) * AW'(9)
                      + AW'(r_s2_sv) * AW'(3) + AW'(r_s2_vv);
        end
    end

    // ------------------------------------------------------------------
    // Counter store: one write port, one registered read port.
    logic [CW-1:0] r_mem [hsvh_pkg::DEPTH];
    logic [CW-1:0] r_rdata;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [CW-1:0] w_wr_data;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_rdata <= r_mem[w_s2_addr];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: read data back, increment or return, and forwarding.
    logic [AW-1:0] r_s3_addr;
    logic          r_s3_read_zero;
    logic          r_fwd_en;
    logic [AW-1:0] r_fwd_addr;
    logic [CW-1:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_advance) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s3_action    <= r_s2_action;
            r_s3_addr      <= w_s2_addr;
            r_s3_read_zero <= r_s2_read_zero;
        end
    end

    // The value read last cycle misses a write made on that same edge.
    logic [CW-1:0] w_cur;
    logic          w_add_wr;
    logic [CW-1:0] w_inc;

    assign w_cur    = (r_fwd_en && (r_fwd_addr == r_s3_addr)) ? r_fwd_data : r_rdata;
    assign w_inc    = (w_cur < hsvh_pkg::COUNT_MAX) ? w_cur + CW'(1) : w_cur;
    assign w_add_wr = w_advance && r_s3_valid && (r_s3_action == hsvh_pkg::ACT_ADD);

    // Write port: the zeroing sweep or an increment.
    always_comb begin
        if (r_sweep) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_sweep_addr;
            w_wr_data = '0;
        end else begin
            w_wr_en   = w_add_wr;
            w_wr_addr = r_s3_addr;
            w_wr_data = w_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_en <= 1'b0;
        end else if (r_sweep) begin
            r_fwd_en <= 1'b0;
        end else if (w_advance) begin
            r_fwd_en <= w_add_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_fwd_addr <= r_s3_addr;
            r_fwd_data <= w_inc;
        end
    end

    // ------------------------------------------------------------------
    // Clear handling: stall input from the clear beat until the sweep ends.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_pend <= 1'b0;
            r_sweep      <= 1'b1;
            r_sweep_addr <= '0;
        end else begin
            if (w_in_accept && (hsvh_pkg::t_action'(i_action) == hsvh_pkg::ACT_CLEAR)) begin
                r_clear_pend <= 1'b1;
            end
            if (r_sweep) begin
                r_sweep_addr <= r_sweep_addr + AW'(1);
                if (r_sweep_addr == AW'(hsvh_pkg::DEPTH - 1)) begin
                    r_sweep <= 1'b0;
                end
            end else if (w_advance && r_s3_valid &&
                         (r_s3_action == hsvh_pkg::ACT_CLEAR)) begin
                r_clear_pend <= 1'b0;
                r_sweep      <= 1'b1;
                r_sweep_addr <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_s3_valid && (r_s3_action == hsvh_pkg::ACT_READ)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_s3_valid && (r_s3_action == hsvh_pkg::ACT_READ)) begin
            r_count <= r_s3_read_zero ? '0 : w_cur;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_count     = r_count;

endmodule
